>>> rtl/fwbp_pkg.sv
`timescale 1ns / 1ps

package fwbp_pkg;

  // Field widths and fixed limits
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned MAX_WIDTH  = 64;
  localparam int unsigned WIDTH_W    = 7;
  localparam int unsigned PEND_W     = 7;
  localparam int unsigned PCOUNT_W   = 3;
  // Merged pending bits plus one shifted word: 7 + 64 bits, rounded to bytes
  localparam int unsigned MERGE_BITS = 72;
  localparam int unsigned NBYTES_W   = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 7'd64;

  // Input request payload
  typedef struct packed {
    logic [WORD_BITS-1:0] value_in;
  } word_t;

  // Output request payload
  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 run_last;
    logic                 block_last;
  } result_t;

endpackage

>>> rtl/fwbp_stream_if.sv
`timescale 1ns / 1ps

interface fwbp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/fixed_width_bit_packer_core.sv
`timescale 1ns / 1ps

// Fixed-width bit packer. Each 64-bit word request keeps its low bit_width bits
// (values above 64 act as 64), appends them least significant first to the
// running bit stream and produces one byte request per completed byte, earlier
// bits in lower positions. After every BLOCK_WORDS words a partial byte is
// zero padded and sent, so each block starts on a byte boundary. run_last
// marks the final byte caused by a word, block_last the final byte of a block.
// Rate: a word that yields n bytes (0 to 9) holds the core until they drain;
// the byte drain register sends one byte per cycle while byte_stream is ready,
// and the next word enters in the same cycle as the prior word's last byte leaves.
// bit_width resets to 8. Write it via cfg_we/cfg_wdata while idle; not enforced.
module fixed_width_bit_packer_core #(
  parameter int unsigned BLOCK_WORDS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fwbp_pkg::WIDTH_W-1:0]     cfg_wdata,
  fwbp_stream_if.sink                      word_stream,
  fwbp_stream_if.source                    byte_stream
);

  localparam int unsigned IDX_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_WORDS - 1);

  // Configuration and packing state
  logic [fwbp_pkg::WIDTH_W-1:0]    bit_width;
  logic [fwbp_pkg::PEND_W-1:0]     pending_bits;
  logic [fwbp_pkg::PCOUNT_W-1:0]   pending_count;
  logic [IDX_W-1:0]                word_index;

  // Byte drain register
  logic [fwbp_pkg::MERGE_BITS-1:0] work_data;
  logic [fwbp_pkg::NBYTES_W-1:0]   work_cnt;
  logic                            work_blk;

  // Output register
  logic                            out_valid;
  fwbp_pkg::result_t               out_data;

  // Combinational packing terms
  logic [fwbp_pkg::WIDTH_W-1:0]    width_sat;
  logic [fwbp_pkg::WORD_BITS-1:0]  keep_mask;
  logic [fwbp_pkg::MERGE_BITS-1:0] merged;
  logic [fwbp_pkg::MERGE_BITS-1:0] tail;
  logic [fwbp_pkg::WIDTH_W-1:0]    total;
  logic [fwbp_pkg::NBYTES_W-1:0]   full_bytes;
  logic [fwbp_pkg::PCOUNT_W-1:0]   rem_bits;
  logic                            block_end;
  logic                            pad;
  logic [fwbp_pkg::NBYTES_W-1:0]   nbytes;

  logic                            out_free;
  logic                            emit;
  logic                            accept;

  // Clamp width and mask the word
  always_comb begin
    width_sat  = (bit_width > fwbp_pkg::WIDTH_MAX) ? fwbp_pkg::WIDTH_MAX : bit_width;
    keep_mask  = (width_sat == fwbp_pkg::WIDTH_MAX) ? '1
               : ((fwbp_pkg::WORD_BITS'(1) << width_sat[5:0]) - fwbp_pkg::WORD_BITS'(1));
    merged     = fwbp_pkg::MERGE_BITS'(pending_bits)
               | (fwbp_pkg::MERGE_BITS'(word_stream.data.value_in & keep_mask)
                  << pending_count);
    total      = fwbp_pkg::WIDTH_W'(pending_count) + width_sat;
    full_bytes = total[6:3];
    rem_bits   = total[2:0];
    block_end  = (word_index == IDX_LAST);
    pad        = block_end && (rem_bits != '0);
    nbytes     = full_bytes + fwbp_pkg::NBYTES_W'(pad);
    tail       = merged >> {full_bytes, 3'b000};
  end

  // Handshake: drain one byte a cycle when out_free, refill as the last byte leaves
  assign out_free = !out_valid || byte_stream.ready;
  assign emit     = (work_cnt != '0) && out_free;
  assign accept   = word_stream.valid && word_stream.ready;

  assign word_stream.ready = (work_cnt == '0)
                           || ((work_cnt == fwbp_pkg::NBYTES_W'(1)) && out_free);
  assign byte_stream.valid = out_valid;
  assign byte_stream.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_width     <= fwbp_pkg::WIDTH_RESET;
      pending_bits  <= '0;
      pending_count <= '0;
      word_index    <= '0;
      work_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      // Take the register write
      if (cfg_we) begin
        bit_width <= cfg_wdata;
      end

      // Advance the output register
      if (emit) begin
        out_valid           <= 1'b1;
        out_data.out_byte   <= work_data[7:0];
        out_data.run_last   <= (work_cnt == fwbp_pkg::NBYTES_W'(1));
        out_data.block_last <= (work_cnt == fwbp_pkg::NBYTES_W'(1)) && work_blk;
      end else if (byte_stream.ready) begin
        out_valid <= 1'b0;
      end

      // Load the accepted word and update the stream state, else shift the drain
      if (accept) begin
        work_data     <= merged;
        work_cnt      <= nbytes;
        work_blk      <= block_end;
        word_index    <= block_end ? '0 : word_index + IDX_W'(1);
        pending_bits  <= pad ? '0 : tail[fwbp_pkg::PEND_W-1:0];
        pending_count <= pad ? '0 : rem_bits;
      end else if (emit) begin
        work_data     <= work_data >> fwbp_pkg::BYTE_BITS;
        work_cnt      <= work_cnt - fwbp_pkg::NBYTES_W'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A word never yields more than nine bytes
  a_work_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    work_cnt <= fwbp_pkg::NBYTES_W'(9))
    else $error("drain count above nine");

  // Bits above the pending count stay clear
  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending_bits >> pending_count) == '0)
    else $error("stale bits above pending count");

  // A block-closing word leaves the stream byte aligned
  a_block_align: assert property (@(posedge clk) disable iff (rst)
    (accept && block_end) |=> (pending_count == '0) && (word_index == '0))
    else $error("block end left a partial byte");

  // The block marker only sits on a word's last byte
  a_block_on_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.block_last) |-> out_data.run_last)
    else $error("block_last without run_last");
`endif

endmodule
